/* rtl/spiq_pkg.sv */
// Shared constants and types for the sorted priority insert queue.
package spiq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int PRI_W     = 16;
    localparam int ENT_W     = VAL_W + PRI_W;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DUMP    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DUMP   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

endpackage

/* rtl/sorted_priority_insert_queue.sv */
// Sorted priority insert queue: bounded store kept in ascending priority order.
//
// Input beats on s_*: s_tuser is the command (insert, dump, restart), s_tdata
// carries the entry. Results on m_*: m_tuser is the status, m_tdata the dumped
// entry (zero otherwise), m_tlast marks the final result of a command.
// s_tready is high only while the sequencer is idle; one command at a time.
// Sequencing:
//   restart, insert into an empty or full store, dump of an empty store:
//     the result goes out from the result state, then the sequencer is idle.
//   insert into a store of N entries: a head read, then the single
//     read/compare/write pass over the entry RAM that shifts K entries (0..N),
//     then a place step for an insert at the head, then the result state.
//   dump of N entries: one RAM read and one beat per cycle while the
//     receiver is ready; the beat marked last ends the command.
// The last result is held in the output register, so the next command is
// accepted while that beat waits. A stalled receiver stops a dump in place.
// Reset empties the store (entry count only); the RAM contents are not cleared
// and need not be, since only entries below the count are ever read.
module sorted_priority_insert_queue
    import spiq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ENT_W-1:0] s_tdata,   // [31:0] item_value, [47:32] item_priority
    input  logic [1:0]       s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [ENT_W-1:0] m_tdata,   // [31:0] out_value, [47:32] out_priority
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_SCAN,
        S_PLACE,
        S_DUMP,
        S_RESULT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [VAL_W-1:0]         val_reg, val_next;
    logic signed [PRI_W-1:0]  pri_reg, pri_next;
    logic                     head_reg, head_next;
    status_t                  res_reg, res_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [ENT_W-1:0]         m_tdata_reg, m_tdata_next;
    logic [1:0]               m_tuser_reg, m_tuser_next;
    logic                     m_tlast_reg, m_tlast_next;

    logic [ENT_W-1:0]         mem [DEPTH];
    logic [ENT_W-1:0]         rd_data_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ENT_W-1:0]         mem_wdata;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;

    logic signed [PRI_W-1:0]  rd_pri;
    logic                     out_free;
    logic                     shift;
    logic                     dump_last;

    assign rd_pri    = $signed(rd_data_reg[ENT_W-1 -: PRI_W]);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign shift     = head_reg || (rd_pri > pri_reg);
    assign dump_last = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        pri_next      = pri_reg;
        head_next     = head_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = {pri_reg, val_reg};
        rd_en         = 1'b0;
        rd_addr       = idx_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        CMD_INSERT: begin
                            if (cnt_reg == CNT_W'(DEPTH)) begin
                                res_next   = ST_FULL;
                                state_next = S_RESULT;
                            end else if (cnt_reg == '0) begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = s_tdata;
                                cnt_next   = CNT_W'(1);
                                res_next   = ST_ACCEPT;
                                state_next = S_RESULT;
                            end else begin
                                val_next   = s_tdata[VAL_W-1:0];
                                pri_next   = $signed(s_tdata[ENT_W-1 -: PRI_W]);
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_HEAD;
                            end
                        end
                        CMD_RESTART: begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = s_tdata;
                            cnt_next   = CNT_W'(1);
                            res_next   = ST_ACCEPT;
                            state_next = S_RESULT;
                        end
                        CMD_DUMP: begin
                            if (cnt_reg == '0) begin
                                res_next   = ST_EMPTY;
                                state_next = S_RESULT;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                // head entry on the read port; not above it means insert at head
                head_next  = (pri_reg <= rd_pri);
                rd_en      = 1'b1;
                rd_addr    = cnt_reg[ADDR_W-1:0] - ADDR_W'(1);
                idx_next   = cnt_reg[ADDR_W-1:0];
                state_next = S_SCAN;
            end
            S_SCAN: begin
                // read port holds entry idx-1; move it up or drop the item at idx
                mem_we = 1'b1;
                if (shift) begin
                    mem_wdata = rd_data_reg;
                    idx_next  = idx_reg - ADDR_W'(1);
                    if (idx_reg == ADDR_W'(1)) begin
                        state_next = S_PLACE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = idx_reg - ADDR_W'(2);
                    end
                end else begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    res_next   = ST_ACCEPT;
                    state_next = S_RESULT;
                end
            end
            S_PLACE: begin
                mem_we     = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                res_next   = ST_ACCEPT;
                state_next = S_RESULT;
            end
            S_DUMP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = ST_DUMP;
                    m_tdata_next  = rd_data_reg;
                    m_tlast_next  = dump_last;
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_W'(1);
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_reg;
                    m_tdata_next  = '0;
                    m_tlast_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        pri_reg     <= pri_next;
        head_reg    <= head_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_restart_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_RESTART) |=> cnt_reg == CNT_W'(1))
        else $error("restart did not leave one entry");

    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_INSERT && cnt_reg == CNT_W'(DEPTH))
        |=> cnt_reg == $past(cnt_reg))
        else $error("insert into full store changed the count");

    a_status_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_DUMP) |-> (m_tlast && m_tdata == '0))
        else $error("status beat not last or carries data");

endmodule
